### rtl/core/bb3_pkg.sv
`timescale 1ns / 1ps

package bb3_pkg;

   // csr register indexes
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam int         CSR_IDX_W        = 2;
   localparam int         CSR_DATA_W       = 10;
   localparam logic [CSR_DATA_W-1:0] FRAME_DIM_RESET = 10'd512;

   // item kinds
   localparam logic ITEM_PIXEL = 1'b0;
   localparam logic ITEM_DRAIN = 1'b1;

   // averaging widths
   localparam int PIX_W   = 24;
   localparam int CH_W    = 8;
   localparam int SUM_W   = 12;
   localparam int CNT_W   = 4;
   localparam int NUM_W   = 13;
   localparam int DEN_W   = 5;
   localparam int RECIP_W = 16;
   localparam int PROD_W  = NUM_W + RECIP_W;

   typedef struct packed {
      logic            req_type;
      logic [CH_W-1:0] in_red;
      logic [CH_W-1:0] in_green;
      logic [CH_W-1:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic            frame_last;
   } rsp_payload_type;

   // floor(2^16 / (2*count)) for the neighbourhood sizes that occur
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd6:    r = 16'd5461;
         4'd9:    r = 16'd3640;
         default: r = 16'd32768;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/bb3_store.sv
`timescale 1ns / 1ps

module bb3_store #(
   parameter int DEPTH  = 1536,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bb3_avg.sv
`timescale 1ns / 1ps

module bb3_avg (
   input  logic                          clock,
   input  logic                          load,
   input  logic [2:0][bb3_pkg::SUM_W-1:0] sums,
   input  logic [bb3_pkg::CNT_W-1:0]     cnt,
   output logic [2:0][bb3_pkg::CH_W-1:0] avgs
);
   import bb3_pkg::*;

   logic [2:0][PROD_W-1:0] prod_ff, prod_in;
   logic [2:0][NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]       den_ff, den_in;

   // numerator 2*sum+count and product with the reciprocal of 2*count
   always_comb begin
      den_in = DEN_W'({cnt, 1'b0});
      for (int i = 0; i < 3; i++) begin
         num_in[i]  = NUM_W'({sums[i], 1'b0}) + NUM_W'(cnt);
         prod_in[i] = PROD_W'(num_in[i]) * PROD_W'(recip(cnt));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   // estimate is exact or one low; one compare fixes it
   always_comb begin
      logic [NUM_W-1:0] q0;
      logic [NUM_W-1:0] rem;
      logic [NUM_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q0  = prod_ff[i][PROD_W-1:RECIP_W];
         rem = num_ff[i] - NUM_W'(q0 * NUM_W'(den_ff));
         q   = (rem >= NUM_W'(den_ff)) ? q0 + NUM_W'(1) : q0;
         avgs[i] = (q > NUM_W'(255)) ? CH_W'(255) : q[CH_W-1:0];
      end
   end

endmodule

### rtl/core/box_blur_3x3.sv
`timescale 1ns / 1ps
// 3x3 box blur, RGB pixels in raster order, results lag input by width+1 items.
// An item that yields a result reads its count neighbours (count = 1..9) through the
// single read port of the row store, one neighbour read per cycle, then passes
// S_FLUSH, S_MUL and S_FIN; an item that yields no result leaves the block idle.
// Synchronous active-high reset clears positions and handshake state; the row
// store is not cleared and needs no clearing pass.
module box_blur_3x3 #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bb3_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bb3_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_wr_en,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bb3_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int CIX_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DEPTH  = 3 * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_FLUSH = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [COL_W-1:0]      in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [1:0]            in_rm3_ff, in_rm3_in, out_rm3_ff, out_rm3_in;
   logic                  done_ff, done_in;
   logic [PIX_W-1:0]      cur_ff, cur_in;
   logic                  is_pixel_ff, is_pixel_in;
   logic [ROW_W-1:0]      rd_row_ff, rd_row_in, row_hi_ff, row_hi_in;
   logic [1:0]            rd_rm3_ff, rd_rm3_in;
   logic [COL_W-1:0]      rd_col_ff, rd_col_in, col_lo_ff, col_lo_in, col_hi_ff, col_hi_in;
   logic                  rd_vld_ff, rd_vld_in, rd_fwd_ff, rd_fwd_in;
   logic [2:0][SUM_W-1:0] sums_ff, sums_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [COL_W-1:0]      eff_w;
   logic [ROW_W-1:0]      eff_h;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [PIX_W-1:0]      wr_data, mem_q, pix;
   logic [2:0][CH_W-1:0]  avgs;
   logic                  accept, lag_hit, rsp_free, last_out;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] rm3,
                                                 input logic [COL_W-1:0] col);
      return ADDR_W'(rm3) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col[CIX_W-1:0]);
   endfunction

   function automatic logic [1:0] inc3(input logic [1:0] v);
      return (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   // frame dimensions saturated to 1..max
   always_comb begin
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = COL_W'(MAX_WIDTH);
      end else begin
         eff_w = COL_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // at least width+1 items already in
   assign lag_hit   = (in_row_ff >= ROW_W'(2)) ||
                      ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign last_out  = (out_row_ff == eff_h - ROW_W'(1)) &&
                      (out_col_ff == eff_w - COL_W'(1));
   assign pix       = rd_fwd_ff ? cur_ff : mem_q;
   assign rd_addr   = addr_of(rd_rm3_ff, rd_col_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_rm3_in    = in_rm3_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_rm3_in   = out_rm3_ff;
      done_in      = done_ff;
      cur_in       = cur_ff;
      is_pixel_in  = is_pixel_ff;
      rd_row_in    = rd_row_ff;
      rd_rm3_in    = rd_rm3_ff;
      rd_col_in    = rd_col_ff;
      row_hi_in    = row_hi_ff;
      col_lo_in    = col_lo_ff;
      col_hi_in    = col_hi_ff;
      rd_vld_in    = 1'b0;
      rd_fwd_in    = 1'b0;
      sums_in      = sums_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_of(in_rm3_ff, in_col_ff);
      wr_data      = cur_ff;

      // gather neighbours as their reads come back
      if (rd_vld_ff) begin
         sums_in[0] = sums_ff[0] + SUM_W'(pix[23:16]);
         sums_in[1] = sums_ff[1] + SUM_W'(pix[15:8]);
         sums_in[2] = sums_ff[2] + SUM_W'(pix[7:0]);
         cnt_in     = cnt_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_in      = {req_data.in_red, req_data.in_green, req_data.in_blue};
               is_pixel_in = (req_data.req_type == ITEM_PIXEL);
               // window of the next output, clipped at the frame edges
               rd_row_in = (out_row_ff == '0) ? '0 : out_row_ff - ROW_W'(1);
               rd_rm3_in = (out_row_ff == '0) ? out_rm3_ff :
                           ((out_rm3_ff == 2'd0) ? 2'd2 : out_rm3_ff - 2'd1);
               row_hi_in = (out_row_ff == eff_h - ROW_W'(1)) ? out_row_ff :
                           out_row_ff + ROW_W'(1);
               col_lo_in = (out_col_ff == '0) ? '0 : out_col_ff - COL_W'(1);
               col_hi_in = (out_col_ff == eff_w - COL_W'(1)) ? out_col_ff :
                           out_col_ff + COL_W'(1);
               rd_col_in = col_lo_in;
               sums_in   = '0;
               cnt_in    = '0;
               if (req_data.req_type == ITEM_PIXEL) begin
                  if (!done_ff) begin
                     if (lag_hit) begin
                        state_in = S_READ;
                     end else begin
                        // no result: store the pixel and move on
                        wr_en   = 1'b1;
                        wr_data = cur_in;
                        if (in_col_ff + COL_W'(1) >= eff_w) begin
                           in_col_in = '0;
                           in_row_in = in_row_ff + ROW_W'(1);
                           in_rm3_in = inc3(in_rm3_ff);
                        end else begin
                           in_col_in = in_col_ff + COL_W'(1);
                        end
                        done_in = (in_row_in >= eff_h);
                     end
                  end
               end else if (done_ff) begin
                  // drain item: position moves before the output
                  if (in_col_ff + COL_W'(1) >= eff_w) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + ROW_W'(1);
                     in_rm3_in = inc3(in_rm3_ff);
                  end else begin
                     in_col_in = in_col_ff + COL_W'(1);
                  end
                  if (lag_hit) begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            rd_vld_in = 1'b1;
            // the pixel of this item is not yet in the store
            rd_fwd_in = is_pixel_ff && (rd_row_ff == in_row_ff) && (rd_col_ff == in_col_ff);
            if (rd_col_ff == col_hi_ff) begin
               rd_col_in = col_lo_ff;
               rd_row_in = rd_row_ff + ROW_W'(1);
               rd_rm3_in = inc3(rd_rm3_ff);
               if (rd_row_ff == row_hi_ff) begin
                  state_in = S_FLUSH;
               end
            end else begin
               rd_col_in = rd_col_ff + COL_W'(1);
            end
         end
         S_FLUSH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in.out_red    = avgs[0];
               rsp_data_in.out_green  = avgs[1];
               rsp_data_in.out_blue   = avgs[2];
               rsp_data_in.frame_last = last_out;
               // pixel write-back after its neighbours were read
               if (is_pixel_ff) begin
                  wr_en = 1'b1;
                  if (in_col_ff + COL_W'(1) >= eff_w) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + ROW_W'(1);
                     in_rm3_in = inc3(in_rm3_ff);
                  end else begin
                     in_col_in = in_col_ff + COL_W'(1);
                  end
                  done_in = (in_row_in >= eff_h);
               end
               if (last_out) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  in_rm3_in  = 2'd0;
                  out_col_in = '0;
                  out_row_in = '0;
                  out_rm3_in = 2'd0;
                  done_in    = 1'b0;
               end else if (out_col_ff + COL_W'(1) >= eff_w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
                  out_rm3_in = inc3(out_rm3_ff);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write restarts the frame
      if (csr_wr_en && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT)) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_wdata;
         end else begin
            height_in = csr_wdata;
         end
         in_col_in  = '0;
         in_row_in  = '0;
         in_rm3_in  = 2'd0;
         out_col_in = '0;
         out_row_in = '0;
         out_rm3_in = 2'd0;
         done_in    = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= FRAME_DIM_RESET;
         height_ff    <= FRAME_DIM_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_rm3_ff    <= 2'd0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_rm3_ff   <= 2'd0;
         done_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_rm3_ff    <= in_rm3_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_rm3_ff   <= out_rm3_in;
         done_ff      <= done_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      is_pixel_ff <= is_pixel_in;
      rd_row_ff   <= rd_row_in;
      rd_rm3_ff   <= rd_rm3_in;
      rd_col_ff   <= rd_col_in;
      row_hi_ff   <= row_hi_in;
      col_lo_ff   <= col_lo_in;
      col_hi_ff   <= col_hi_in;
      rd_fwd_ff   <= rd_fwd_in;
      sums_ff     <= sums_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // three rows of pixels
   bb3_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (PIX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (state_ff == S_READ),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   // rounded mean per channel
   bb3_avg u_avg (
      .clock (clock),
      .load  (state_ff == S_MUL),
      .sums  (sums_ff),
      .cnt   (cnt_ff),
      .avgs  (avgs)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
